// ===== src/ycbcr420_quad_to_rgb_defines.svh =====
// Assertion macros for the YCbCr 4:2:0 quad converter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef YCBCR420_QUAD_TO_RGB_DEFINES_SVH
`define YCBCR420_QUAD_TO_RGB_DEFINES_SVH

// pre holds at one edge, post must hold at the next
`define YCQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ycq: next-cycle check failed");

// pre and post must hold together
`define YCQ_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ycq: same-cycle check failed");

`endif

// ===== src/ycq_pkg.sv =====
// Shared types, constants and register codes for the YCbCr 4:2:0 quad converter.
// No dependencies.
`timescale 1ns / 1ps

package ycq_pkg;

  localparam int LANES         = 4;
  localparam int FRAC_BITS_DEF = 14;
  // signed accumulator width: covers the largest sum plus rounding for 8..16 fraction bits
  localparam int SUM_W         = 27;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int COEF_W        = 16;

  localparam logic [8:0] Y_OFFSET = 9'd16;
  localparam logic [8:0] C_OFFSET = 9'd128;

  // register indexes (address bits [4:2])
  localparam logic [2:0] REG_LUMA_GAIN   = 3'd0;
  localparam logic [2:0] REG_CR_TO_RED   = 3'd1;
  localparam logic [2:0] REG_CR_TO_GREEN = 3'd2;
  localparam logic [2:0] REG_CB_TO_GREEN = 3'd3;
  localparam logic [2:0] REG_CB_TO_BLUE  = 3'd4;

  localparam logic [COEF_W-1:0] RST_LUMA_GAIN   = 16'd19071;
  localparam logic [COEF_W-1:0] RST_CR_TO_RED   = 16'd26149;
  localparam logic [COEF_W-1:0] RST_CR_TO_GREEN = 16'd13320;
  localparam logic [COEF_W-1:0] RST_CB_TO_GREEN = 16'd6406;
  localparam logic [COEF_W-1:0] RST_CB_TO_BLUE  = 16'd33063;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [7:0]       chroma_t;

  typedef struct packed {
    logic [COEF_W-1:0] luma_gain;
    logic [COEF_W-1:0] cr_to_red;
    logic [COEF_W-1:0] cr_to_green;
    logic [COEF_W-1:0] cb_to_green;
    logic [COEF_W-1:0] cb_to_blue;
  } coef_t;

endpackage

// ===== src/ycbcr420_quad_to_rgb.sv =====
// YCbCr 4:2:0 quad to RGB converter, top level.
// An accepted quad passes the input register, then the result register drives the output.
// Throughput: one quad per cycle while out_ready holds, set by the lanes' single registered pass.
// Reset (rst_n low, synchronous): drop any transaction in flight, restore default coefficients.
// Depends on ycq_pkg, ycq_regs, ycq_upsample, ycq_lane and the defines header.
`timescale 1ns / 1ps
`include "ycbcr420_quad_to_rgb_defines.svh"

module ycbcr420_quad_to_rgb #(
  parameter int FRAC_BITS = ycq_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ycq_pkg::ADDR_W-1:0] paddr,
  input  logic [ycq_pkg::DATA_W-1:0] pwdata,
  output logic [ycq_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_y_top_left,
  input  logic [7:0]                 in_y_top_right,
  input  logic [7:0]                 in_y_bottom_left,
  input  logic [7:0]                 in_y_bottom_right,
  input  logic [7:0]                 in_cb_here,
  input  logic [7:0]                 in_cb_right,
  input  logic [7:0]                 in_cb_below,
  input  logic [7:0]                 in_cb_below_right,
  input  logic [7:0]                 in_cr_here,
  input  logic [7:0]                 in_cr_right,
  input  logic [7:0]                 in_cr_below,
  input  logic [7:0]                 in_cr_below_right,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_red_top_left,
  output logic [7:0]                 out_red_top_right,
  output logic [7:0]                 out_red_bottom_left,
  output logic [7:0]                 out_red_bottom_right,
  output logic [7:0]                 out_green_top_left,
  output logic [7:0]                 out_green_top_right,
  output logic [7:0]                 out_green_bottom_left,
  output logic [7:0]                 out_green_bottom_right,
  output logic [7:0]                 out_blue_top_left,
  output logic [7:0]                 out_blue_top_right,
  output logic [7:0]                 out_blue_bottom_left,
  output logic [7:0]                 out_blue_bottom_right
);

  localparam int LANES = ycq_pkg::LANES;

  // ---------------------------------------------------------------------------
  // Coefficient registers. Writes complete in the access phase, no wait states.
  // ---------------------------------------------------------------------------
  ycq_pkg::coef_t coef;

  assign pready = 1'b1;

  ycq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  // ---------------------------------------------------------------------------
  // Handshake. Two register stages: the input register and the result register.
  // The input register advances whenever the result register is free or being
  // drained, so a new transaction is taken every cycle while the sink keeps up,
  // and one waiting result does not stop the next quad from being captured.
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic in_accept;
  logic s2_load;

  assign s2_load   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s2_load;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept)
      s1_valid_nxt = 1'b1;
    else if (s2_load)
      s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s2_load)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Input register: hold the raw quad until it moves into the result register.
  // ---------------------------------------------------------------------------
  logic [7:0] y_r  [LANES];
  logic [7:0] cb_r [LANES];
  logic [7:0] cr_r [LANES];

  always_ff @(posedge clk) begin
    if (in_accept) begin
      y_r[0]  <= in_y_top_left;
      y_r[1]  <= in_y_top_right;
      y_r[2]  <= in_y_bottom_left;
      y_r[3]  <= in_y_bottom_right;
      cb_r[0] <= in_cb_here;
      cb_r[1] <= in_cb_right;
      cb_r[2] <= in_cb_below;
      cb_r[3] <= in_cb_below_right;
      cr_r[0] <= in_cr_here;
      cr_r[1] <= in_cr_right;
      cr_r[2] <= in_cr_below;
      cr_r[3] <= in_cr_below_right;
    end
  end

  // ---------------------------------------------------------------------------
  // Single pass: upsample chroma per lane, then four parallel colour lanes.
  // Lane order is top left, top right, bottom left, bottom right.
  // ---------------------------------------------------------------------------
  ycq_pkg::chroma_t cb_lane [LANES];
  ycq_pkg::chroma_t cr_lane [LANES];
  logic [7:0]       red   [LANES];
  logic [7:0]       green [LANES];
  logic [7:0]       blue  [LANES];

  ycq_upsample u_up_cb (
    .here        (cb_r[0]),
    .right       (cb_r[1]),
    .below       (cb_r[2]),
    .below_right (cb_r[3]),
    .lane        (cb_lane)
  );

  ycq_upsample u_up_cr (
    .here        (cr_r[0]),
    .right       (cr_r[1]),
    .below       (cr_r[2]),
    .below_right (cr_r[3]),
    .lane        (cr_lane)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ycq_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .y     (y_r[i]),
      .cb    (cb_lane[i]),
      .cr    (cr_lane[i]),
      .coef  (coef),
      .red   (red[i]),
      .green (green[i]),
      .blue  (blue[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register: hold the clamped pixels while the sink stalls.
  // ---------------------------------------------------------------------------
  logic [7:0] red_r   [LANES];
  logic [7:0] green_r [LANES];
  logic [7:0] blue_r  [LANES];

  always_ff @(posedge clk) begin
    if (s2_load) begin
      for (int i = 0; i < LANES; i++) begin
        red_r[i]   <= red[i];
        green_r[i] <= green[i];
        blue_r[i]  <= blue[i];
      end
    end
  end

  assign out_red_top_left       = red_r[0];
  assign out_red_top_right      = red_r[1];
  assign out_red_bottom_left    = red_r[2];
  assign out_red_bottom_right   = red_r[3];
  assign out_green_top_left     = green_r[0];
  assign out_green_top_right    = green_r[1];
  assign out_green_bottom_left  = green_r[2];
  assign out_green_bottom_right = green_r[3];
  assign out_blue_top_left      = blue_r[0];
  assign out_blue_top_right     = blue_r[1];
  assign out_blue_bottom_left   = blue_r[2];
  assign out_blue_bottom_right  = blue_r[3];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // an accepted quad always lands in the input register
  `YCQ_ASSERT_NEXT(a_capture, in_accept, s1_valid_r)
  // a quad leaving the input register always shows up as a result
  `YCQ_ASSERT_NEXT(a_advance, s2_load, out_valid_r)
  // an empty input register never refuses a transaction
  `YCQ_ASSERT_SAME(a_ready_empty, !s1_valid_r, in_ready)
  // a luma gain write takes effect on the next cycle
  `YCQ_ASSERT_NEXT(a_cfg_write,
    psel && penable && pwrite && (paddr[ycq_pkg::ADDR_W-1:2] == ycq_pkg::REG_LUMA_GAIN),
    coef.luma_gain == $past(pwdata[ycq_pkg::COEF_W-1:0]))

endmodule

// ===== src/ycq_regs.sv =====
// Coefficient register file behind the APB-style port.
// Depends on ycq_pkg.
`timescale 1ns / 1ps

module ycq_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ycq_pkg::ADDR_W-1:0]  paddr,
  input  logic [ycq_pkg::DATA_W-1:0]  pwdata,
  output logic [ycq_pkg::DATA_W-1:0]  prdata,
  output ycq_pkg::coef_t              coef
);

  ycq_pkg::coef_t coef_r;
  ycq_pkg::coef_t coef_nxt;
  logic [2:0]     idx;
  logic           wr;

  assign idx = paddr[ycq_pkg::ADDR_W-1:2];
  assign wr  = psel && penable && pwrite;

  always_comb begin
    coef_nxt = coef_r;
    if (wr) begin
      case (idx)
        ycq_pkg::REG_LUMA_GAIN:   coef_nxt.luma_gain   = pwdata[ycq_pkg::COEF_W-1:0];
        ycq_pkg::REG_CR_TO_RED:   coef_nxt.cr_to_red   = pwdata[ycq_pkg::COEF_W-1:0];
        ycq_pkg::REG_CR_TO_GREEN: coef_nxt.cr_to_green = pwdata[ycq_pkg::COEF_W-1:0];
        ycq_pkg::REG_CB_TO_GREEN: coef_nxt.cb_to_green = pwdata[ycq_pkg::COEF_W-1:0];
        ycq_pkg::REG_CB_TO_BLUE:  coef_nxt.cb_to_blue  = pwdata[ycq_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.luma_gain   <= ycq_pkg::RST_LUMA_GAIN;
      coef_r.cr_to_red   <= ycq_pkg::RST_CR_TO_RED;
      coef_r.cr_to_green <= ycq_pkg::RST_CR_TO_GREEN;
      coef_r.cb_to_green <= ycq_pkg::RST_CB_TO_GREEN;
      coef_r.cb_to_blue  <= ycq_pkg::RST_CB_TO_BLUE;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  always_comb begin
    case (idx)
      ycq_pkg::REG_LUMA_GAIN:   prdata = ycq_pkg::DATA_W'(coef_r.luma_gain);
      ycq_pkg::REG_CR_TO_RED:   prdata = ycq_pkg::DATA_W'(coef_r.cr_to_red);
      ycq_pkg::REG_CR_TO_GREEN: prdata = ycq_pkg::DATA_W'(coef_r.cr_to_green);
      ycq_pkg::REG_CB_TO_GREEN: prdata = ycq_pkg::DATA_W'(coef_r.cb_to_green);
      ycq_pkg::REG_CB_TO_BLUE:  prdata = ycq_pkg::DATA_W'(coef_r.cb_to_blue);
      default:                  prdata = '0;
    endcase
  end

  assign coef = coef_r;

endmodule

// ===== src/ycq_upsample.sv =====
// Chroma upsampler: four neighbour samples to four centred per-pixel values.
// Depends on ycq_pkg.
`timescale 1ns / 1ps

module ycq_upsample (
  input  logic [7:0]       here,
  input  logic [7:0]       right,
  input  logic [7:0]       below,
  input  logic [7:0]       below_right,
  output ycq_pkg::chroma_t lane [ycq_pkg::LANES]
);

  function automatic ycq_pkg::chroma_t centre(input logic [7:0] u);
    logic [8:0] w;
    w = {1'b0, u} - ycq_pkg::C_OFFSET;
    return ycq_pkg::chroma_t'(w[7:0]);
  endfunction

  logic [8:0] sum_h;
  logic [8:0] sum_v;
  logic [9:0] sum_q;

  assign sum_h = {1'b0, here} + {1'b0, right};
  assign sum_v = {1'b0, here} + {1'b0, below};
  assign sum_q = {2'b00, here} + {2'b00, right} + {2'b00, below} + {2'b00, below_right};

  assign lane[0] = centre(here);
  assign lane[1] = centre(sum_h[8:1]);
  assign lane[2] = centre(sum_v[8:1]);
  assign lane[3] = centre(sum_q[9:2]);

endmodule

// ===== src/ycq_lane.sv =====
// One pixel lane: coefficient products, rounding, floor shift and clamp to a byte.
// Depends on ycq_pkg.
`timescale 1ns / 1ps

module ycq_lane #(
  parameter int FRAC_BITS = ycq_pkg::FRAC_BITS_DEF
) (
  input  logic [7:0]       y,
  input  ycq_pkg::chroma_t cb,
  input  ycq_pkg::chroma_t cr,
  input  ycq_pkg::coef_t   coef,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  localparam ycq_pkg::sum_t ROUND = ycq_pkg::sum_t'(1) <<< (FRAC_BITS - 1);

  function automatic logic [7:0] finish(input ycq_pkg::sum_t s);
    ycq_pkg::sum_t q;
    q = (s + ROUND) >>> FRAC_BITS;
    if (q[ycq_pkg::SUM_W-1])
      return 8'd0;
    else if (|q[ycq_pkg::SUM_W-2:8])
      return 8'd255;
    else
      return q[7:0];
  endfunction

  logic [8:0]    y_off;
  ycq_pkg::sum_t y_s;
  ycq_pkg::sum_t cb_s;
  ycq_pkg::sum_t cr_s;
  ycq_pkg::sum_t base;
  ycq_pkg::sum_t p_crr;
  ycq_pkg::sum_t p_crg;
  ycq_pkg::sum_t p_cbg;
  ycq_pkg::sum_t p_cbb;

  assign y_off = {1'b0, y} - ycq_pkg::Y_OFFSET;
  assign y_s   = ycq_pkg::sum_t'($signed(y_off));
  assign cb_s  = ycq_pkg::sum_t'(cb);
  assign cr_s  = ycq_pkg::sum_t'(cr);

  // coefficients are unsigned: zero-extend into the signed accumulator
  assign base  = ycq_pkg::sum_t'({1'b0, coef.luma_gain})   * y_s;
  assign p_crr = ycq_pkg::sum_t'({1'b0, coef.cr_to_red})   * cr_s;
  assign p_crg = ycq_pkg::sum_t'({1'b0, coef.cr_to_green}) * cr_s;
  assign p_cbg = ycq_pkg::sum_t'({1'b0, coef.cb_to_green}) * cb_s;
  assign p_cbb = ycq_pkg::sum_t'({1'b0, coef.cb_to_blue})  * cb_s;

  assign red   = finish(base + p_crr);
  assign green = finish(base - p_crg - p_cbg);
  assign blue  = finish(base + p_cbb);

endmodule
